// ===== src/rnorm_pkg.sv =====
// Shared constants, types and helpers for the rational normalizer.
package rnorm_pkg;

  localparam int WIDTH = 32;
  localparam int CNT_W = $clog2(WIDTH);

  typedef logic [WIDTH-1:0] word_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GCD,
    S_DIV_NUM,
    S_SWITCH,
    S_DIV_DEN,
    S_DONE
  } rnorm_state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic gcd_step;
    logic g_load;
    logic div_init;
    logic div_sel;   // 0: numerator magnitude, 1: denominator magnitude
    logic div_step;
    logic qn_save;
    logic out_load;
  } rnorm_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic gcd_done;
    logic g_zero;
    logic div_last;
  } rnorm_sts_t;

  // Two's complement magnitude; the most negative value maps to 2^(WIDTH-1)
  function automatic word_t mag(input word_t v);
    mag = v[WIDTH-1] ? (~v + word_t'(1)) : v;
  endfunction

endpackage

// ===== src/rnorm_dp.sv =====
// Datapath: binary gcd unit, shared restoring divider and result register.
module rnorm_dp import rnorm_pkg::*; (
  input  logic       clk,
  input  rnorm_cmd_t cmd,
  input  word_t      num_in,
  input  word_t      den_in,
  output rnorm_sts_t sts,
  output word_t      num_out,
  output word_t      den_out
);

  word_t num_r, den_r;
  word_t a_r, b_r;
  cnt_t  k_r;
  word_t g_r;
  word_t rem_r, dvd_r;
  cnt_t  cnt_r;
  word_t qn_r;
  word_t out_num_r, out_den_r;

  word_t a_nxt, b_nxt;
  cnt_t  k_nxt;
  word_t rem_sh, rem_nxt, dvd_nxt;
  logic  ge;
  word_t qn_s, qd_s, rn, rd;

  assign sts.gcd_done = (a_r == '0) || (b_r == '0);
  assign sts.g_zero   = (a_r | b_r) == '0;
  assign sts.div_last = cnt_r == cnt_t'(WIDTH - 1);

  // One Stein step: strip factors of two, else subtract the smaller odd value
  always_comb begin
    a_nxt = a_r;
    b_nxt = b_r;
    k_nxt = k_r;
    if (!a_r[0] && !b_r[0]) begin
      a_nxt = a_r >> 1;
      b_nxt = b_r >> 1;
      k_nxt = k_r + cnt_t'(1);
    end else if (!a_r[0]) begin
      a_nxt = a_r >> 1;
    end else if (!b_r[0]) begin
      b_nxt = b_r >> 1;
    end else if (a_r >= b_r) begin
      a_nxt = (a_r - b_r) >> 1;
    end else begin
      b_nxt = (b_r - a_r) >> 1;
    end
  end

  // Restoring division step; remainder stays below g, so the shift fits
  always_comb begin
    rem_sh  = {rem_r[WIDTH-2:0], dvd_r[WIDTH-1]};
    ge      = rem_sh >= g_r;
    rem_nxt = ge ? (rem_sh - g_r) : rem_sh;
    dvd_nxt = {dvd_r[WIDTH-2:0], ge};
  end

  // Restore signs, then move the sign onto the numerator
  always_comb begin
    qn_s = num_r[WIDTH-1] ? (~qn_r + word_t'(1)) : qn_r;
    qd_s = den_r[WIDTH-1] ? (~dvd_r + word_t'(1)) : dvd_r;
    if (g_r == '0) begin
      rn = num_r;
      rd = den_r;
    end else begin
      rn = qn_s;
      rd = qd_s;
    end
    if (rd[WIDTH-1]) begin
      rn = ~rn + word_t'(1);
      rd = ~rd + word_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      num_r <= num_in;
      den_r <= den_in;
      a_r   <= mag(den_in);
      b_r   <= mag(num_in);
      k_r   <= '0;
    end else if (cmd.gcd_step) begin
      a_r <= a_nxt;
      b_r <= b_nxt;
      k_r <= k_nxt;
    end
    if (cmd.g_load) begin
      g_r <= (a_r | b_r) << k_r;
    end
    if (cmd.div_init) begin
      dvd_r <= cmd.div_sel ? mag(den_r) : mag(num_r);
      rem_r <= '0;
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
      cnt_r <= cnt_r + cnt_t'(1);
    end
    if (cmd.qn_save) begin
      qn_r <= dvd_r;
    end
    if (cmd.out_load) begin
      out_num_r <= rn;
      out_den_r <= rd;
    end
  end

  assign num_out = out_num_r;
  assign den_out = out_den_r;

endmodule

// ===== src/rnorm_ctrl.sv =====
// Controller: sequences gcd, the two divisions (skipped for 0/0) and the output handshake.
module rnorm_ctrl import rnorm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  rnorm_sts_t sts,
  output rnorm_cmd_t cmd
);

  rnorm_state_t state_r, state_nxt;
  logic         out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_GCD;
        end
      end
      S_GCD: begin
        if (sts.gcd_done) begin
          cmd.g_load   = 1'b1;
          cmd.div_init = 1'b1;
          cmd.div_sel  = 1'b0;
          // both parts zero: nothing to divide
          state_nxt    = sts.g_zero ? S_DONE : S_DIV_NUM;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      S_DIV_NUM: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = S_SWITCH;
      end
      S_SWITCH: begin
        cmd.qn_save  = 1'b1;
        cmd.div_init = 1'b1;
        cmd.div_sel  = 1'b1;
        state_nxt    = S_DIV_DEN;
      end
      S_DIV_DEN: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = S_DONE;
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

`ifndef NO_ASSERTIONS
  a_accept_starts_gcd: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_GCD)
    else $error("accepted item did not start gcd");

  a_num_div_to_switch: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV_NUM && sts.div_last |=> state_r == S_SWITCH)
    else $error("numerator division did not hand over");

  a_load_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r && state_r == S_IDLE)
    else $error("result load did not raise out_valid");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !out_valid_r || out_ready)
    else $error("pending result overwritten");
`endif

endmodule

// ===== src/rational_normalizer.sv =====
// Top level of the rational normalizer: reduces a signed fraction to lowest terms.
// Each item takes a numerator and a denominator and returns the fraction in lowest
// terms with the sign on the numerator; 0/0 passes through, n/0 gives sign(n)/0, and
// negation of the most negative value wraps. The block works on one item at a time:
// a binary gcd unit takes one step per cycle until one of its two values reaches zero,
// then one shared restoring divider produces the two quotients one bit per cycle,
// numerator first, with a switch state between the two. A finished result sits in an
// output register, and the next item is accepted while it waits.
module rational_normalizer import rnorm_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [WIDTH-1:0] in_numerator_in,
  input  logic signed [WIDTH-1:0] in_denominator_in,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [WIDTH-1:0] out_numerator_out,
  output logic signed [WIDTH-1:0] out_denominator_out
);

  rnorm_cmd_t cmd;
  rnorm_sts_t sts;
  word_t      num_q, den_q;

  rnorm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rnorm_dp u_dp (
    .clk     (clk),
    .cmd     (cmd),
    .num_in  (word_t'(in_numerator_in)),
    .den_in  (word_t'(in_denominator_in)),
    .sts     (sts),
    .num_out (num_q),
    .den_out (den_q)
  );

  assign out_numerator_out   = $signed(num_q);
  assign out_denominator_out = $signed(den_q);

endmodule
